@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the sharpening filter modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ design/rss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_pkg
// Types and constants of the 3x3 RGB sharpening filter.
// ----------------------------------------------------------------------------
package rss_pkg;

	localparam int COORD_W = 12;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_GAIN   = 2'd2;

	localparam logic [12:0] RST_WIDTH  = 13'd4000;
	localparam logic [11:0] RST_HEIGHT = 12'd3000;
	localparam logic [7:0]  RST_GAIN   = 8'd32;

	// Smallest frame dimension the filter works with.
	localparam int MIN_DIM = 3;

	// Bit positions of the result kinds one pixel may cause, in output order.
	localparam int EMIT_MAIN   = 0; // window result for (r-1, c-1)
	localparam int EMIT_RIGHT  = 1; // right border of the previous row
	localparam int EMIT_BOTTOM = 2; // bottom row, column c-1
	localparam int EMIT_CORNER = 3; // bottom right pixel of the frame

	typedef logic [23:0] pix_t; // blue in [23:16], green in [15:8], red in [7:0]

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} pix_req_t;

	typedef struct packed {
		logic [7:0]         red_out;
		logic [7:0]         green_out;
		logic [7:0]         blue_out;
		logic [COORD_W-1:0] out_row;
		logic [COORD_W-1:0] out_col;
		logic               run_last;
		logic               frame_last;
	} res_rsp_t;

	typedef struct packed {
		logic               interior;
		logic [3:0]         emits;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} emit_meta_t;

	typedef struct packed {
		logic load_a;
		logic load_b;
	} lane_ctl_t;

endpackage

@@ design/rss_line_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_line_buf
// Two-row line store: one read port and one write port, registered read.
// ----------------------------------------------------------------------------
module rss_line_buf #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [47:0]   rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [47:0]   wr_data
);

	logic [47:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ design/rss_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_lane
// One color channel of the sharpening kernel, two pipeline stages.
// ----------------------------------------------------------------------------
module rss_lane (
	input  logic                clk,
	input  rss_pkg::lane_ctl_t  ctl,
	input  logic [7:0]          gain,
	input  logic [8:0][7:0]     taps,
	output logic [7:0]          value
);
	import rss_pkg::*;

	logic [10:0]        nbr_sum;
	logic signed [11:0] diff;
	logic signed [11:0] diff_s3;
	logic [7:0]         centre_s3;
	logic signed [20:0] prod;
	logic signed [21:0] acc;
	logic signed [21:0] acc_s4;
	logic [14:0]        scaled;

	// Sum of the eight neighbours and the Laplacian term 8c - s.
	always_comb begin
		nbr_sum = '0;
		for (int k = 0; k < 9; k++) begin
			if (k != 4) begin
				nbr_sum = nbr_sum + 11'(taps[k]);
			end
		end
		diff = $signed({1'b0, taps[4], 3'b000}) - $signed({1'b0, nbr_sum});
	end

	always_ff @(posedge clk) begin
		if (ctl.load_a) begin
			diff_s3   <= diff;
			centre_s3 <= taps[4];
		end
	end

	always_comb begin
		prod = $signed({1'b0, gain}) * diff_s3;
		acc  = $signed(22'(prod)) + $signed(22'({centre_s3, 6'b000000}));
	end

	always_ff @(posedge clk) begin
		if (ctl.load_b) begin
			acc_s4 <= acc;
		end
	end

	// Divide by 64 with floor and clamp to a byte.
	always_comb begin
		scaled = acc_s4[20:6];
		if (acc_s4[21]) begin
			value = '0;
		end else if (scaled > 15'd255) begin
			value = 8'd255;
		end else begin
			value = scaled[7:0];
		end
	end

endmodule

@@ design/rss_emit.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// rss_emit
// Merges the three lane results with the pixel position and sends the
// results of one pixel one per cycle while res_ready is high.
// ----------------------------------------------------------------------------
module rss_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  rss_pkg::emit_meta_t meta,
	input  rss_pkg::pix_t       rgb,
	output logic                stage_ready,
	output logic                res_valid,
	input  logic                res_ready,
	output rss_pkg::res_rsp_t   res_data
);
	import rss_pkg::*;

	logic [3:0]         pending_q;
	logic               interior_q;
	logic [COORD_W-1:0] row_q;
	logic [COORD_W-1:0] col_q;
	pix_t               rgb_q;
	logic [3:0]         sel;
	logic               single;
	logic               prev_row;
	logic               prev_col;
	logic               take;

	assign sel       = pending_q & (~pending_q + 4'd1);
	assign single    = (pending_q & (pending_q - 4'd1)) == 4'd0;
	assign res_valid = pending_q != 4'd0;
	assign take      = res_valid && res_ready;
	assign stage_ready = !res_valid || (res_ready && single);

	assign prev_row = sel[EMIT_MAIN] | sel[EMIT_RIGHT];
	assign prev_col = sel[EMIT_MAIN] | sel[EMIT_BOTTOM];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (load) begin
			pending_q <= meta.emits;
		end else if (take) begin
			pending_q <= pending_q & ~sel;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			interior_q <= meta.interior;
			row_q      <= meta.row;
			col_q      <= meta.col;
			rgb_q      <= rgb;
		end
	end

	always_comb begin
		res_data = '0;
		if (sel[EMIT_MAIN] && interior_q) begin
			res_data.red_out   = rgb_q[7:0];
			res_data.green_out = rgb_q[15:8];
			res_data.blue_out  = rgb_q[23:16];
		end
		res_data.out_row    = prev_row ? row_q - 12'd1 : row_q;
		res_data.out_col    = prev_col ? col_q - 12'd1 : col_q;
		res_data.run_last   = single;
		res_data.frame_last = sel[EMIT_CORNER];
	end

	`ASSERT_IMPLY(a_frame_last_ends_run, clk, arst_n, (res_valid && res_data.frame_last), res_data.run_last)
	`ASSERT_NEXT(a_stall_holds_pending, clk, arst_n, (res_valid && !res_ready), $stable(pending_q))
	`ASSERT_IMPLY(a_load_only_when_free, clk, arst_n, load, stage_ready)

endmodule

@@ design/rgb_sharpen_3x3_stream.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// rgb_sharpen_3x3_stream
// Streaming 3x3 Laplacian sharpening of RGB pixels in raster order.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake           Moves
//   pix       in          pix_valid/ready     one RGB pixel request
//   res       out         res_valid/ready     one sharpened result with position
//   apb       in          psel/penable        width, height and gain registers
//
// One pixel is taken per cycle while each pixel causes at most one result and res
// is not stalled. A row-end pixel past row 0, or a last-row pixel past column 0,
// causes two to four results, sent one per cycle while res_ready is high. Results
// pass line store read, window shift, two lane stages and the emit register.
// Reset clears the counters and pipeline valids; the line store is not cleared.
// Result stalls back up stage by stage, so bubbles are filled before input holds.
// ----------------------------------------------------------------------------
module rgb_sharpen_3x3_stream #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_ready,
	input  rss_pkg::pix_req_t pix_data,
	output logic              res_valid,
	input  logic              res_ready,
	output rss_pkg::res_rsp_t res_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import rss_pkg::*;

	// Column counters index the line store; the effective width may equal
	// MAX_WIDTH itself and needs one more bit.
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int XW = (WW > 13) ? WW : 13;

	// Configuration registers.
	logic [12:0] image_width_q;
	logic [11:0] image_height_q;
	logic [7:0]  gain_eighths_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= RST_WIDTH;
			image_height_q <= RST_HEIGHT;
			gain_eighths_q <= RST_GAIN;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_WIDTH:  image_width_q  <= pwdata[12:0];
				REG_HEIGHT: image_height_q <= pwdata[11:0];
				REG_GAIN:   gain_eighths_q <= pwdata[7:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WIDTH:  prdata = 32'(image_width_q);
			REG_HEIGHT: prdata = 32'(image_height_q);
			REG_GAIN:   prdata = 32'(gain_eighths_q);
			default:    prdata = '0;
		endcase
	end

	// Effective frame size: width clamped to MIN_DIM..MAX_WIDTH, height to at
	// least MIN_DIM.
	logic [XW-1:0] w_raw;
	logic [XW-1:0] w_clamp;
	logic [WW-1:0] w_eff;
	logic [WW-1:0] w_m1;
	logic [11:0]   h_eff;
	logic [11:0]   h_m1;

	always_comb begin
		w_raw = XW'(image_width_q);
		if (w_raw < XW'(MIN_DIM)) begin
			w_clamp = XW'(MIN_DIM);
		end else if (w_raw > XW'(MAX_WIDTH)) begin
			w_clamp = XW'(MAX_WIDTH);
		end else begin
			w_clamp = w_raw;
		end
		w_eff = w_clamp[WW-1:0];
		w_m1  = w_eff - WW'(1);
		h_eff = (image_height_q < 12'(MIN_DIM)) ? 12'(MIN_DIM) : image_height_q;
		h_m1  = h_eff - 12'd1;
	end

	// Position of the incoming pixel. The counters normally wrap as the last
	// pixel of a row is taken; the wrap before use only matters when the size
	// was lowered in the middle of a frame.
	logic [AW-1:0] col_q;
	logic [11:0]   row_q;
	logic          pre_wrap;
	logic [AW-1:0] col_sel;
	logic [12:0]   row_pre;
	logic [11:0]   row_sel;
	logic          col_last;
	logic          row_last;
	logic [AW-1:0] col_nxt;
	logic [11:0]   row_nxt;
	emit_meta_t    meta_in;
	logic          pix_acc;

	always_comb begin
		pre_wrap = WW'(col_q) >= w_eff;
		col_sel  = pre_wrap ? '0 : col_q;
		row_pre  = pre_wrap ? {1'b0, row_q} + 13'd1 : {1'b0, row_q};
		row_sel  = (row_pre >= {1'b0, h_eff}) ? '0 : row_pre[11:0];
		col_last = WW'(col_sel) == w_m1;
		row_last = row_sel == h_m1;

		meta_in.interior           = (row_sel > 12'd1) && (col_sel > AW'(1));
		meta_in.emits[EMIT_MAIN]   = (row_sel != '0) && (col_sel != '0);
		meta_in.emits[EMIT_RIGHT]  = (row_sel != '0) && col_last;
		meta_in.emits[EMIT_BOTTOM] = row_last && (col_sel != '0);
		meta_in.emits[EMIT_CORNER] = row_last && col_last;
		meta_in.row                = row_sel;
		meta_in.col                = COORD_W'(col_sel);

		if (col_last) begin
			col_nxt = '0;
			row_nxt = row_last ? '0 : row_sel + 12'd1;
		end else begin
			col_nxt = col_sel + AW'(1);
			row_nxt = row_sel;
		end
	end

	assign pix_acc = pix_valid && pix_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

	// Pipeline control. Each stage takes a new request when it is empty or
	// its occupant moves on in the same cycle.
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic adv12;

	assign rdy4      = !valid_s4 || rdy5;
	assign rdy3      = !valid_s3 || rdy4;
	assign rdy2      = !valid_s2 || rdy3;
	assign rdy1      = !valid_s1 || rdy2;
	assign pix_ready = rdy1;
	assign adv12     = valid_s1 && rdy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= pix_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	// Stage 1: line store read in flight. The pixel's own column is written
	// back when it leaves this stage; the next pixel always reads another
	// column, so the delayed write never meets a read of the same entry.
	pix_t          pix_s1;
	logic [AW-1:0] addr_s1;
	emit_meta_t    meta_s1, meta_s2, meta_s3, meta_s4;
	logic [47:0]   line_rd;
	logic          mem_wr_en;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			pix_s1  <= {pix_data.blue_in, pix_data.green_in, pix_data.red_in};
			addr_s1 <= col_sel;
			meta_s1 <= meta_in;
		end
	end

	assign mem_wr_en = adv12;

	// Upper row in the high half, middle row in the low half.
	rss_line_buf #(
		.DEPTH(MAX_WIDTH),
		.AW   (AW)
	) u_line_buf (
		.clk    (clk),
		.rd_en  (pix_acc),
		.rd_addr(col_sel),
		.rd_data(line_rd),
		.wr_en  (mem_wr_en),
		.wr_addr(addr_s1),
		.wr_data({line_rd[23:0], pix_s1})
	);

	// Stage 2: the 3x3 window shifts left by one column as a pixel enters.
	pix_t win_q [9];

	always_ff @(posedge clk) begin
		if (adv12) begin
			for (int k = 0; k < 3; k++) begin
				win_q[3*k]     <= win_q[3*k + 1];
				win_q[3*k + 1] <= win_q[3*k + 2];
			end
			win_q[2] <= line_rd[47:24];
			win_q[5] <= line_rd[23:0];
			win_q[8] <= pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) meta_s2 <= meta_s1;
		if (rdy3) meta_s3 <= meta_s2;
		if (rdy4) meta_s4 <= meta_s3;
	end

	// Stages 3 and 4: one lane per color channel.
	logic [2:0][8:0][7:0] lane_taps;
	logic [2:0][7:0]      lane_val;
	lane_ctl_t            lane_ctl;

	assign lane_ctl.load_a = rdy3;
	assign lane_ctl.load_b = rdy4;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			for (int k = 0; k < 9; k++) begin
				lane_taps[l][k] = win_q[k][8*l +: 8];
			end
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_lane
		rss_lane u_lane (
			.clk  (clk),
			.ctl  (lane_ctl),
			.gain (gain_eighths_q),
			.taps (lane_taps[l]),
			.value(lane_val[l])
		);
	end

	// Stage 5: merge the lanes and send the pixel's results.
	rss_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (valid_s4 && rdy5),
		.meta       (meta_s4),
		.rgb        ({lane_val[2], lane_val[1], lane_val[0]}),
		.stage_ready(rdy5),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data)
	);

	`ASSERT_IMPLY(a_line_rw_apart, clk, arst_n, (mem_wr_en && pix_acc), (addr_s1 != col_sel))
	`ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, pix_acc, valid_s1)
	`ASSERT_IMPLY(a_col_in_range, clk, arst_n, pix_acc, (WW'(col_nxt) < w_eff))

endmodule
